FILE: hw/rtl/mdm_pkg.sv
package mdm_pkg;

  localparam int unsigned MDM_RAMP_STEPS = 50;

  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned DZ_W      = 8;
  localparam int unsigned INV_W     = 4;
  localparam int unsigned AXIS_W    = 8;
  localparam int unsigned CMD_W     = 11;
  localparam int unsigned MAG_W     = 10;
  localparam int unsigned DUTY_W    = 8;
  localparam int unsigned NWHEEL    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 40;

  localparam int unsigned RECIP_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DRIVE_GAIN  = 2'd0,
    CFG_DEAD_ZONE   = 2'd1,
    CFG_INVERT_MASK = 2'd2
  } cfg_reg_t;

  typedef logic signed [CMD_W-1:0] cmd_t;

endpackage

FILE: hw/rtl/mecanum_drive_mixer.sv
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+-----------------------------------------------
// s_axis   | in  | s_tvalid / s_tready  | s_tdata sticks and buttons, s_tuser link_up
// m_axis   | out | m_tvalid / m_tready  | m_tdata four wheels dir+duty, m_tuser ramping
// cfg      | in  | cfg_valid/cfg_ready  | cfg_index register, cfg_data value
//
// one tick per cycle unless m stalls: input register, one pass of mixing or ramp logic,
// result register, which drives m_tvalid; the ramp divides incrementally, so no
// divider sits in the path, only one reciprocal multiply on the first ramp step
// reset clears the channels, the registers to 128/30/5 and the kept commands
// a stalled m side holds the result and the input register, then s_tready drops
module mecanum_drive_mixer #(
  parameter int unsigned RAMP_STEPS = mdm_pkg::MDM_RAMP_STEPS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // stick_x[7:0], stick_y[15:8], turn_right[16], turn_left[17], zero pad
  input  logic [mdm_pkg::S_TDATA_W-1:0]   s_tdata,
  // link_up[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // fl_dir[0], fl_duty[8:1], fr_dir[9], fr_duty[17:10], rl_dir[18], rl_duty[26:19],
  // rr_dir[27], rr_duty[35:28], zero pad
  output logic [mdm_pkg::M_TDATA_W-1:0]   m_tdata,
  // ramping[0]
  output logic                            m_tuser,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mdm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);
  import mdm_pkg::*;

  localparam int unsigned CW = $clog2(RAMP_STEPS + 1);
  localparam logic [CW-1:0] NSTEPS = CW'(RAMP_STEPS);
  localparam logic [RECIP_SHIFT:0] RECIP =
    (RECIP_SHIFT+1)'(((1 << RECIP_SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS);
  localparam int unsigned PROD_W = MAG_W + RECIP_SHIFT + 1;

  // configuration
  logic [GAIN_W-1:0] drive_gain;
  logic [DZ_W-1:0]   dead_zone;
  logic [INV_W-1:0]  invert_mask;

  // input register
  logic                   in_vld;
  logic                   in_link;
  logic [AXIS_W-1:0]      in_sx;
  logic [AXIS_W-1:0]      in_sy;
  logic                   in_tr;
  logic                   in_tl;

  // state
  cmd_t              kept      [NWHEEL];
  cmd_t              kept_next [NWHEEL];
  logic [CW-1:0]     ramp_count, ramp_count_next;
  logic              ramp_active, ramp_active_next;
  logic              stopped_flag, stopped_flag_next;
  logic [MAG_W-1:0]  rq      [NWHEEL];
  logic [MAG_W-1:0]  rq_next [NWHEEL];
  logic [CW-1:0]     rr      [NWHEEL];
  logic [CW-1:0]     rr_next [NWHEEL];
  logic [MAG_W-1:0]  qa      [NWHEEL];
  logic [MAG_W-1:0]  qa_next [NWHEEL];
  logic [CW-1:0]     ra      [NWHEEL];
  logic [CW-1:0]     ra_next [NWHEEL];

  // result register
  logic                  out_vld;
  logic [M_TDATA_W-1:0]  out_data, out_data_next;
  logic                  out_ramp, out_ramp_next;

  logic advance;
  logic fire;

  assign advance   = !out_vld || m_tready;
  assign s_tready  = !in_vld || advance;
  assign fire      = in_vld && advance;
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_vld;
  assign m_tdata   = out_data;
  assign m_tuser   = out_ramp;

  function automatic logic signed [AXIS_W:0] dz_axis(input logic [AXIS_W-1:0] raw,
                                                     input logic [DZ_W-1:0] dz);
    logic signed [AXIS_W:0] a;
    logic signed [AXIS_W:0] mag;
    a   = -$signed({raw[AXIS_W-1], raw});
    mag = a[AXIS_W] ? -a : a;
    return ($unsigned(mag) < {1'b0, dz}) ? '0 : a;
  endfunction

  // truncating divide by 128
  function automatic cmd_t div128(input logic signed [17:0] v);
    logic signed [17:0] t;
    t = v + (v[17] ? 18'sd127 : 18'sd0);
    return cmd_t'(t[17:7]);
  endfunction

  // returns {duty, dir}
  function automatic logic [DUTY_W:0] to_pwm(input cmd_t c, input logic inv);
    cmd_t v;
    cmd_t m;
    v = inv ? -c : c;
    if (v > 11'sd255) begin
      v = 11'sd255;
    end else if (v < -11'sd255) begin
      v = -11'sd255;
    end
    m = v[CMD_W-1] ? -v : v;
    return {m[DUTY_W-1:0], ~v[CMD_W-1]};
  endfunction

  // mixing
  logic signed [AXIS_W:0] ax, ay;
  logic signed [17:0]     xg, yg, rg;
  logic signed [17:0]     sum [NWHEEL];
  cmd_t                   mix [NWHEEL];

  always_comb begin
    ax = dz_axis(in_sx, dead_zone);
    ay = dz_axis(in_sy, dead_zone);
    xg = 18'(ax * $signed({1'b0, drive_gain}));
    yg = 18'(ay * $signed({1'b0, drive_gain}));
    if (in_tr) begin
      rg = -$signed(18'({drive_gain, 7'd0}));
    end else if (in_tl) begin
      rg = $signed(18'({drive_gain, 7'd0}));
    end else begin
      rg = '0;
    end
    sum[0] = yg + xg + rg;
    sum[1] = yg - xg - rg;
    sum[2] = yg - xg + rg;
    sum[3] = yg + xg - rg;
    for (int i = 0; i < NWHEEL; i++) begin
      mix[i] = div128(sum[i]);
    end
  end

  // ramp arithmetic
  logic [MAG_W-1:0]  amag  [NWHEEL];
  logic [PROD_W-1:0] prod  [NWHEEL];
  logic [MAG_W-1:0]  qa0   [NWHEEL];
  logic [MAG_W:0]    rfull [NWHEEL];
  logic [CW-1:0]     ra0   [NWHEEL];
  logic [CW:0]       rsum  [NWHEEL];
  logic              brw   [NWHEEL];
  logic [MAG_W-1:0]  rstep_q [NWHEEL];
  logic [CW-1:0]     rstep_r [NWHEEL];
  cmd_t              neg_k [NWHEEL];

  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      neg_k[i] = -kept[i];
      amag[i]  = kept[i][CMD_W-1] ? neg_k[i][MAG_W-1:0] : kept[i][MAG_W-1:0];
      prod[i]  = PROD_W'(amag[i] * RECIP);
      qa0[i]   = prod[i][RECIP_SHIFT +: MAG_W];
      rfull[i] = {1'b0, amag[i]} - (MAG_W+1)'(qa0[i] * NSTEPS);
      ra0[i]   = rfull[i][CW-1:0];
      if (ramp_count == '0) begin
        brw[i]     = (ra0[i] != '0);
        rstep_q[i] = amag[i] - qa0[i] - MAG_W'(brw[i]);
        rsum[i]    = brw[i] ? ({1'b0, NSTEPS} - {1'b0, ra0[i]}) : '0;
      end else begin
        brw[i]     = (rr[i] < ra[i]);
        rstep_q[i] = rq[i] - qa[i] - MAG_W'(brw[i]);
        rsum[i]    = {1'b0, rr[i]} + (brw[i] ? {1'b0, NSTEPS} : '0) - {1'b0, ra[i]};
      end
      rstep_r[i] = rsum[i][CW-1:0];
    end
  end

  // tick control
  logic              start;
  logic              act;
  logic [CW-1:0]     cnt;
  logic [MAG_W-1:0]  step_mag;
  cmd_t              cmd [NWHEEL];

  always_comb begin
    start             = !ramp_active && !in_link && !stopped_flag;
    act               = ramp_active || start;
    cnt               = start ? '0 : ramp_count;
    ramp_count_next   = ramp_count;
    ramp_active_next  = ramp_active;
    stopped_flag_next = stopped_flag;
    out_ramp_next     = 1'b0;
    step_mag          = '0;
    for (int i = 0; i < NWHEEL; i++) begin
      kept_next[i] = kept[i];
      rq_next[i]   = rq[i];
      rr_next[i]   = rr[i];
      qa_next[i]   = qa[i];
      ra_next[i]   = ra[i];
      cmd[i]       = '0;
    end
    if (act) begin
      ramp_active_next = 1'b1;
      if (cnt < NSTEPS) begin
        ramp_count_next = cnt + 1'b1;
        out_ramp_next   = 1'b1;
        for (int i = 0; i < NWHEEL; i++) begin
          rq_next[i] = rstep_q[i];
          rr_next[i] = rstep_r[i];
          if (cnt == '0) begin
            qa_next[i] = qa0[i];
            ra_next[i] = ra0[i];
            step_mag   = amag[i];
          end else begin
            step_mag   = rq[i];
          end
          cmd[i] = kept[i][CMD_W-1] ? -cmd_t'({1'b0, step_mag}) : cmd_t'({1'b0, step_mag});
        end
      end else begin
        ramp_active_next  = 1'b0;
        ramp_count_next   = '0;
        stopped_flag_next = 1'b1;
        for (int i = 0; i < NWHEEL; i++) begin
          kept_next[i] = '0;
        end
      end
    end else if (in_link) begin
      stopped_flag_next = 1'b0;
      for (int i = 0; i < NWHEEL; i++) begin
        cmd[i]       = mix[i];
        kept_next[i] = mix[i];
      end
    end else begin
      for (int i = 0; i < NWHEEL; i++) begin
        kept_next[i] = '0;
      end
    end
    out_data_next = '0;
    for (int i = 0; i < NWHEEL; i++) begin
      out_data_next[i*(DUTY_W+1) +: DUTY_W+1] = to_pwm(cmd[i], invert_mask[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_gain  <= GAIN_W'(128);
      dead_zone   <= DZ_W'(30);
      invert_mask <= INV_W'(5);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_DRIVE_GAIN:  drive_gain  <= cfg_data;
        CFG_DEAD_ZONE:   dead_zone   <= cfg_data;
        CFG_INVERT_MASK: invert_mask <= cfg_data[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_link <= s_tuser;
      in_sx   <= s_tdata[7:0];
      in_sy   <= s_tdata[15:8];
      in_tr   <= s_tdata[16];
      in_tl   <= s_tdata[17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld      <= 1'b0;
      ramp_count   <= '0;
      ramp_active  <= 1'b0;
      stopped_flag <= 1'b0;
      for (int i = 0; i < NWHEEL; i++) begin
        kept[i] <= '0;
      end
    end else begin
      if (fire) begin
        out_vld      <= 1'b1;
        ramp_count   <= ramp_count_next;
        ramp_active  <= ramp_active_next;
        stopped_flag <= stopped_flag_next;
        for (int i = 0; i < NWHEEL; i++) begin
          kept[i] <= kept_next[i];
        end
      end else if (m_tready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= out_data_next;
      out_ramp <= out_ramp_next;
      for (int i = 0; i < NWHEEL; i++) begin
        rq[i] <= rq_next[i];
        rr[i] <= rr_next[i];
        qa[i] <= qa_next[i];
        ra[i] <= ra_next[i];
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    ramp_count <= NSTEPS)
    else $error("ramp count past the step count");

  a_ramp_xor_stop: assert property (@(posedge clk) disable iff (rst)
    !(ramp_active && stopped_flag))
    else $error("ramp running while stopped");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    ramp_active && ramp_count != '0 |-> rr[0] < NSTEPS && rr[3] < NSTEPS)
    else $error("ramp remainder out of range");

  a_link_clears_stop: assert property (@(posedge clk) disable iff (rst)
    fire && in_link && !ramp_active |=> !stopped_flag)
    else $error("stop flag kept after link returned");

endmodule

FILE: tb/sv/tb_mecanum_drive_mixer.sv
module tb_mecanum_drive_mixer;
  timeunit 1ns;
  timeprecision 1ps;

  import mdm_pkg::*;

  localparam int RAMP = int'(MDM_RAMP_STEPS);
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [3:0]      dir;
    logic [3:0][7:0] duty;
    logic            ramping;
  } wheel_cmd_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 s_tuser;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  mecanum_drive_mixer dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register mirror and drive state
  int         gain_r;
  int         dz_r;
  logic [3:0] inv_r;
  int         kept_cmd [4];
  int         ramp_cnt;
  bit         ramp_on;
  bit         stopped;

  wheel_cmd_t wheel_q [$];
  bit         idle_en;
  int         hold_req;
  int         n_err;
  int         n_sent;
  int         n_mix;
  int         n_ramp;
  int         n_close;
  int         n_stop;
  int         n_cfg;
  string      wheel_name [4] = '{"front_left", "front_right", "rear_left", "rear_right"};

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  initial begin
    #5ms;
    $display("tb_mecanum_drive_mixer NOT OK");
    $finish;
  end

  function automatic int dz_axis(logic signed [7:0] raw);
    int a;
    a = -int'(raw);
    if ((a < 0 ? -a : a) < dz_r)
      a = 0;
    return a;
  endfunction

  function automatic wheel_cmd_t mix_tick(bit link, logic signed [7:0] sx, logic signed [7:0] sy,
                                          bit tr, bit tl);
    int         cmd [4];
    int         x;
    int         y;
    int         r;
    int         left;
    int         v;
    wheel_cmd_t res;
    res = '0;
    if (!ramp_on && !link && !stopped) begin
      ramp_on  = 1'b1;
      ramp_cnt = 0;
    end
    if (ramp_on) begin
      if (ramp_cnt < RAMP) begin
        left = RAMP - ramp_cnt;
        for (int i = 0; i < 4; i++)
          cmd[i] = kept_cmd[i] * left / RAMP;
        ramp_cnt    = (ramp_cnt + 1) & 'h3f;
        res.ramping = 1'b1;
        n_ramp++;
      end else begin
        for (int i = 0; i < 4; i++) begin
          cmd[i]      = 0;
          kept_cmd[i] = 0;
        end
        ramp_on  = 1'b0;
        ramp_cnt = 0;
        stopped  = 1'b1;
        n_close++;
      end
    end else if (link) begin
      x = dz_axis(sx);
      y = dz_axis(sy);
      r = tr ? -128 : (tl ? 128 : 0);
      cmd[0] = (y + x + r) * gain_r / 128;
      cmd[1] = (y - x - r) * gain_r / 128;
      cmd[2] = (y - x + r) * gain_r / 128;
      cmd[3] = (y + x - r) * gain_r / 128;
      for (int i = 0; i < 4; i++)
        kept_cmd[i] = cmd[i];
      stopped = 1'b0;
      n_mix++;
    end else begin
      for (int i = 0; i < 4; i++) begin
        cmd[i]      = 0;
        kept_cmd[i] = 0;
      end
      n_stop++;
    end
    for (int w = 0; w < 4; w++) begin
      v = inv_r[w] ? -cmd[w] : cmd[w];
      if (v > 255)
        v = 255;
      if (v < -255)
        v = -255;
      res.dir[w]  = (v >= 0);
      res.duty[w] = 8'(v < 0 ? -v : v);
    end
    return res;
  endfunction

  // one tick over the s side, called and left at a rising edge
  task automatic send_tick(bit link, logic signed [7:0] sx, logic signed [7:0] sy,
                           bit tr, bit tl);
    int gap;
    if (idle_en && $urandom_range(0, 99) < 8) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= link;
    s_tdata  <= {6'b0, tl, tr, sy, sx};
    do @(posedge clk); while (!s_tready);
    wheel_q.push_back(mix_tick(link, sx, sy, tr, tl));
    n_sent++;
  endtask

  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 9))
      0: return 8'h80;
      1: return 8'h7f;
      2: return 8'h00;
      3: return 8'(dz_r);
      4: return 8'(-dz_r);
      5: return 8'(dz_r - 1);
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_random(bit link);
    send_tick(link, pick_axis(), pick_axis(), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DRIVE_GAIN:  gain_r = val;
      CFG_DEAD_ZONE:   dz_r   = val;
      CFG_INVERT_MASK: inv_r  = val[3:0];
      default: ;
    endcase
    n_cfg++;
  endtask

  task automatic set_config(int g, int dz, int inv);
    drain();
    cfg_put(CFG_DRIVE_GAIN, 8'(g));
    cfg_put(CFG_DEAD_ZONE, 8'(dz));
    // upper nibble is don't-care for the mask
    cfg_put(CFG_INVERT_MASK, {4'($urandom), 4'(inv)});
    cfg_valid <= 1'b0;
  endtask

  task automatic test_ramp_from_reset();
    repeat (RAMP + 3) send_random(1'b0);
    send_tick(1'b1, -8'sd100, 8'sd90, 1'b0, 1'b0);
  endtask

  task automatic test_mix_extremes();
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b0);
    send_tick(1'b1,  8'sd127,  8'sd127, 1'b0, 1'b0);
    send_tick(1'b1, -8'sd128,  8'sd127, 1'b0, 1'b0);
    send_tick(1'b1,  8'sd127, -8'sd128, 1'b0, 1'b0);
    send_tick(1'b1,  8'sd0,    8'sd0,   1'b1, 1'b0);
    send_tick(1'b1,  8'sd0,    8'sd0,   1'b0, 1'b1);
    send_tick(1'b1,  8'sd0,    8'sd0,   1'b1, 1'b1);
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b1);
    send_tick(1'b1,  8'sd29,  -8'sd29,  1'b0, 1'b0);
    send_tick(1'b1,  8'sd30,  -8'sd30,  1'b0, 1'b0);
    send_tick(1'b1, -8'sd31,   8'sd31,  1'b1, 1'b0);
    send_tick(1'b1,  8'sd1,   -8'sd1,   1'b0, 1'b0);
  endtask

  task automatic test_registers();
    set_config(255, 0, 15);
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b1);
    send_tick(1'b1,  8'sd1,    8'sd0,   1'b0, 1'b0);
    send_tick(1'b1,  8'sd127, -8'sd128, 1'b1, 1'b0);
    set_config(0, 128, 0);
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b1, 1'b0);
    send_tick(1'b1,  8'sd127,  8'sd127, 1'b0, 1'b1);
    set_config(64, 128, 10);
    send_tick(1'b1, -8'sd128,  8'sd127, 1'b0, 1'b0);
    send_tick(1'b1,  8'sd127, -8'sd128, 1'b0, 1'b0);
    set_config(128, 129, 6);
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b0);
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b1);
    set_config(200, 255, 9);
    send_tick(1'b1,  8'sd127, -8'sd128, 1'b1, 1'b1);
    // a write to the spare index must leave every register alone
    drain();
    cfg_put(CFG_UNUSED, 8'($urandom));
    cfg_valid <= 1'b0;
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b0);
    set_config(128, 30, 5);
  endtask

  task automatic test_ramp_and_stop();
    send_tick(1'b1, -8'sd128, -8'sd128, 1'b0, 1'b1);
    repeat (RAMP + 4) send_random(1'b0);
    send_tick(1'b1, 8'sd127, -8'sd60, 1'b1, 1'b0);
    // short drop: the ramp keeps going through the returning link
    send_tick(1'b0, 8'sd0, 8'sd0, 1'b0, 1'b0);
    repeat (RAMP + 2) send_random(1'b1);
  endtask

  task automatic test_output_backpressure();
    idle_en  = 1'b0;
    hold_req = HOLD_CYCLES;
    repeat (40) send_random(1'b1);
    drain();
    idle_en = 1'b1;
  endtask

  task automatic test_sender_pause();
    repeat (20) send_random(1'b1);
    drain();
    repeat (20) send_random(1'b1);
  endtask

  task automatic run_random_phase(int n);
    int start;
    int up_len;
    int down_len;
    start = n_sent;
    while (n_sent - start < n) begin
      if ($urandom_range(0, 99) < 75) begin
        up_len = $urandom_range(3, 40);
        repeat (up_len) send_random(1'b1);
        down_len = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 6) : $urandom_range(51, 58);
        repeat (down_len) send_random(1'b0);
      end else begin
        repeat (8) send_random(1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_settings();
    int g_set [8]  = '{128, 0, 255, 255, 64, 200, -1, -1};
    int dz_set [8] = '{30, 0, 0, 128, 255, 129, -1, -1};
    int iv_set [8] = '{5, 15, 0, 15, 10, 3, -1, -1};
    for (int p = 0; p < 8; p++) begin
      set_config(g_set[p] < 0 ? $urandom_range(0, 255) : g_set[p],
                 dz_set[p] < 0 ? $urandom_range(0, 128) : dz_set[p],
                 iv_set[p] < 0 ? $urandom_range(0, 15) : iv_set[p]);
      idle_en = (p != 3);
      run_random_phase(180);
    end
    idle_en = 1'b1;
  endtask

  initial begin : ready_gen
    int hold_cnt;
    hold_cnt = 0;
    m_tready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(idle_en && $urandom_range(0, 99) < 8);
      end
    end
  end

  task automatic report(string what, int want, int got);
    n_err++;
    if (n_err <= 40)
      $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_out
    wheel_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (wheel_q.size() == 0) begin
        n_err++;
        if (n_err <= 40)
          $display("%0t unexpected transfer: expected none actual %h/%b", $time, m_tdata, m_tuser);
      end else begin
        want = wheel_q.pop_front();
        for (int w = 0; w < 4; w++) begin
          if (m_tdata[w*9] !== want.dir[w])
            report({wheel_name[w], " dir"}, want.dir[w], m_tdata[w*9]);
          if (m_tdata[w*9+1 +: 8] !== want.duty[w])
            report({wheel_name[w], " duty"}, want.duty[w], m_tdata[w*9+1 +: 8]);
        end
        if (m_tuser !== want.ramping)
          report("ramping", want.ramping, m_tuser);
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DRIVE_GAIN;
    cfg_data  <= '0;
    gain_r    = 128;
    dz_r      = 30;
    inv_r     = 4'd5;
    kept_cmd  = '{0, 0, 0, 0};
    ramp_cnt  = 0;
    ramp_on   = 1'b0;
    stopped   = 1'b0;
    idle_en   = 1'b1;
    hold_req  = 0;
    n_err     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_ramp_from_reset();
    test_mix_extremes();
    test_registers();
    test_ramp_and_stop();
    test_output_backpressure();
    test_sender_pause();
    test_random_settings();
    drain();

    $display("covered %0d ticks: %0d mixed, %0d ramp steps, %0d ramp ends, %0d stopped",
             n_sent, n_mix, n_ramp, n_close, n_stop);
    $display("%0d register writes, one %0d-cycle output stall, %0d mismatches",
             n_cfg, HOLD_CYCLES, n_err);
    if (n_err == 0) begin
      $display("tb_mecanum_drive_mixer OK");
    end else begin
      $display("tb_mecanum_drive_mixer NOT OK");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/mdm_pkg.sv
hw/rtl/mecanum_drive_mixer.sv
tb/sv/tb_mecanum_drive_mixer.sv
